// ----- rtl/bdm_sws_pkg.sv -----
// Shared types and constants for the background debug serial word shifter.
package bdm_sws_pkg;

    localparam int unsigned FRAME_BITS = 17;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned BITS_W     = 5;

    localparam logic [FRAME_BITS-1:0] TOP_BIT   = 17'h10000;
    localparam logic [FRAME_BITS-1:0] BERR_WORD = 17'h10001;

    // Completion codes reported on the fault field
    typedef enum logic [2:0] {
        FLT_OK        = 3'd0,
        FLT_RESET     = 3'd1,
        FLT_CABLE     = 3'd2,
        FLT_POWER     = 3'd3,
        FLT_BUS_ERR   = 3'd4,
        FLT_NOT_VALID = 3'd5
    } t_fault;

    // One tick of pin-level input
    typedef struct packed {
        logic              start_req;
        logic [WORD_W-1:0] send_word;
        logic              holdback;
        logic              cable_connected;
        logic              target_powered;
        logic              target_in_reset;
        logic              data_in_bar;
    } t_in_item;

    // One tick of pin-level output
    typedef struct packed {
        logic                  clock_low_drive;
        logic                  data_out;
        logic                  busy_res;
        logic                  done_res;
        logic [FRAME_BITS-1:0] received_word;
        t_fault                fault;
    } t_out_item;

    // Handshake between the pipeline stages
    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage

// ----- rtl/bdm_sws_in_stage.sv -----
// Input register stage: captures one tick of pin input per transaction.
module bdm_sws_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  bdm_sws_pkg::t_in_item i_item,
    input  logic                  i_advance,
    output bdm_sws_pkg::t_in_item o_item,
    output logic                  o_valid
);
    import bdm_sws_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Accept when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_advance;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;
endmodule

// ----- rtl/bdm_sws_core.sv -----
// Serial engine state and the per-tick next-state and output logic.
module bdm_sws_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  bdm_sws_pkg::t_in_item         i_item,
    input  logic [bdm_sws_pkg::WORD_W-1:0] i_phase_delay,
    output bdm_sws_pkg::t_out_item        o_item
);
    import bdm_sws_pkg::*;

    logic [FRAME_BITS-1:0] r_shift_reg, n_shift_reg;
    logic [BITS_W-1:0]     r_bits_left, n_bits_left;
    logic [WORD_W-1:0]     r_phase_count, n_phase_count;
    logic                  r_high_phase, n_high_phase;
    logic                  r_active, n_active;
    logic                  r_data_bit, n_data_bit;

    logic [WORD_W-1:0] half_delay;
    assign half_delay = {1'b0, i_phase_delay[WORD_W-1:1]};

    // Step the engine by one tick
    always_comb begin
        logic [FRAME_BITS-1:0] sh;
        logic [BITS_W-1:0]     bl;
        logic [WORD_W-1:0]     pc;
        logic                  hp;
        logic                  db;
        logic                  act;
        logic [FRAME_BITS-1:0] frame;
        t_out_item             res;

        sh    = r_shift_reg;
        bl    = r_bits_left;
        pc    = r_phase_count;
        hp    = r_high_phase;
        db    = r_data_bit;
        act   = r_active;
        frame = {1'b0, i_item.send_word};
        res   = '0;
        res.fault = FLT_OK;

        priority if (!r_active && !i_item.start_req) begin
            // idle tick: all outputs low
        end else if (!r_active && !i_item.cable_connected) begin
            res.done_res = 1'b1;
            res.fault    = FLT_CABLE;
        end else if (!r_active && !i_item.target_powered) begin
            res.done_res = 1'b1;
            res.fault    = FLT_POWER;
        end else if (!r_active && i_item.target_in_reset) begin
            res.done_res = 1'b1;
            res.fault    = FLT_RESET;
        end else begin
            // Start tick doubles as the first clock-low tick
            if (!r_active) begin
                act = 1'b1;
                bl  = BITS_W'(FRAME_BITS) - {{(BITS_W-1){1'b0}}, i_item.holdback};
                db  = frame[FRAME_BITS-1];
                sh  = {frame[FRAME_BITS-2:0], 1'b0};
                hp  = 1'b0;
                pc  = '0;
            end
            res.busy_res = 1'b1;
            res.data_out = db;
            if (!hp) begin
                // Clock-low phase, sample on its last tick
                res.clock_low_drive = 1'b1;
                if (pc == i_phase_delay) begin
                    if (!i_item.data_in_bar) begin
                        sh[0] = 1'b1;
                    end
                    hp = 1'b1;
                    pc = '0;
                end else begin
                    pc = pc + 1'b1;
                end
            end else if (pc != half_delay) begin
                pc = pc + 1'b1;
            end else begin
                bl = bl - 1'b1;
                if (bl != '0) begin
                    // Advance to the next bit
                    db = sh[FRAME_BITS-1];
                    sh = {sh[FRAME_BITS-2:0], 1'b0};
                    hp = 1'b0;
                    pc = '0;
                end else begin
                    // Frame complete: report and classify
                    res.done_res      = 1'b1;
                    res.received_word = sh;
                    if (sh[FRAME_BITS-1]) begin
                        if (sh == BERR_WORD) begin
                            res.fault = FLT_BUS_ERR;
                        end else if (sh != TOP_BIT) begin
                            res.fault = FLT_NOT_VALID;
                        end
                    end
                    act = 1'b0;
                    hp  = 1'b0;
                    pc  = '0;
                end
            end
        end

        n_shift_reg   = sh;
        n_bits_left   = bl;
        n_phase_count = pc;
        n_high_phase  = hp;
        n_data_bit    = db;
        n_active      = act;
        o_item        = res;
    end

    // Hold engine state between ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_reg   <= '0;
            r_bits_left   <= '0;
            r_phase_count <= '0;
            r_high_phase  <= 1'b0;
            r_active      <= 1'b0;
            r_data_bit    <= 1'b0;
        end else if (i_step) begin
            r_shift_reg   <= n_shift_reg;
            r_bits_left   <= n_bits_left;
            r_phase_count <= n_phase_count;
            r_high_phase  <= n_high_phase;
            r_active      <= n_active;
            r_data_bit    <= n_data_bit;
        end
    end
endmodule

// ----- rtl/bdm_sws_out_stage.sv -----
// Result register stage: holds one output tick until the consumer takes it.
module bdm_sws_out_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bdm_sws_pkg::t_out_item i_item,
    input  logic                   i_ready,
    output bdm_sws_pkg::t_stage_ctl o_ctl,
    input  logic                   i_load,
    output bdm_sws_pkg::t_out_item o_item
);
    import bdm_sws_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // Free to load when empty or when the held result leaves now
    assign o_ctl.advance = !r_valid || i_ready;
    assign o_ctl.valid   = r_valid;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ctl.advance) begin
            r_valid <= i_load;
        end
    end

    // Capture result
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_item = r_item;
endmodule

// ----- rtl/bdm_serial_word_shifter.sv -----
// Top level of the background debug serial word shifter.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  input   | i_valid / o_ready  | start_req, send_word, holdback, pins, data_in_bar
//  output  | o_valid / i_ready  | clock_low_drive, data_out, busy/done, word, fault
//  config  | i_cfg_we           | i_cfg_data -> phase_delay
//
// One transaction per cycle in both directions unless stalled; each input transaction gives
// exactly one result transaction, via the input register and then the result register.
// The engine state steps once per input transaction, so a serial frame spans
// 17 * (phase_delay + (phase_delay >> 1) + 2) transactions, 16 * that with holdback.
// Synchronous active-low reset returns the engine to idle and phase_delay to 0.
// A stalled result holds the input register, which then stalls the input channel.
module bdm_serial_word_shifter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_start_req,
    input  logic [15:0] i_send_word,
    input  logic        i_holdback,
    input  logic        i_cable_connected,
    input  logic        i_target_powered,
    input  logic        i_target_in_reset,
    input  logic        i_data_in_bar,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_clock_low_drive,
    output logic        o_data_out,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [16:0] o_received_word,
    output logic [2:0]  o_fault
);
    import bdm_sws_pkg::*;

    logic [WORD_W-1:0] r_phase_delay;
    t_in_item          in_item;
    t_in_item          held_item;
    logic              held_valid;
    t_out_item         step_item;
    t_out_item         out_item;
    t_stage_ctl        out_ctl;
    logic              step;

    // Write configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_delay <= '0;
        end else if (i_cfg_we) begin
            r_phase_delay <= i_cfg_data;
        end
    end

    // Pack input pins
    always_comb begin
        in_item.start_req       = i_start_req;
        in_item.send_word       = i_send_word;
        in_item.holdback        = i_holdback;
        in_item.cable_connected = i_cable_connected;
        in_item.target_powered  = i_target_powered;
        in_item.target_in_reset = i_target_in_reset;
        in_item.data_in_bar     = i_data_in_bar;
    end

    // Step the engine when a held tick can move into the result register
    assign step = held_valid && out_ctl.advance;

    bdm_sws_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .i_advance (out_ctl.advance),
        .o_item    (held_item),
        .o_valid   (held_valid)
    );

    bdm_sws_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (held_item),
        .i_phase_delay (r_phase_delay),
        .o_item        (step_item)
    );

    bdm_sws_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (step_item),
        .i_ready (i_ready),
        .o_ctl   (out_ctl),
        .i_load  (step),
        .o_item  (out_item)
    );

    // Unpack result
    assign o_valid           = out_ctl.valid;
    assign o_clock_low_drive = out_item.clock_low_drive;
    assign o_data_out        = out_item.data_out;
    assign o_busy_res        = out_item.busy_res;
    assign o_done_res        = out_item.done_res;
    assign o_received_word   = out_item.received_word;
    assign o_fault           = out_item.fault;
endmodule

// ----- rtl/bdm_sws_checker.sv -----
// Port-level checks for the serial word shifter, bound to the top level.
module bdm_sws_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_clock_low_drive,
    input logic        o_data_out,
    input logic        o_busy_res,
    input logic        o_done_res,
    input logic [16:0] o_received_word,
    input logic [2:0]  o_fault
);
    import bdm_sws_pkg::*;

    // A pin fault never starts a transfer
    a_pin_fault_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res && (o_fault == FLT_RESET || o_fault == FLT_CABLE ||
        o_fault == FLT_POWER) |-> !o_busy_res && o_received_word == '0)
        else $error("pin fault reported while busy or with data");

    // Idle ticks drive nothing on the serial pins
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> !o_clock_low_drive && !o_data_out)
        else $error("serial pins driven while idle");

    // Word and fault appear only on a completing tick
    a_word_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_received_word == '0 && o_fault == FLT_OK)
        else $error("word or fault without done");

    // Bus error word is classified as such
    a_bus_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res && o_busy_res && o_received_word == BERR_WORD
        |-> o_fault == FLT_BUS_ERR)
        else $error("bus error word misclassified");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_received_word) && $stable(o_fault))
        else $error("stalled result changed");
endmodule

bind bdm_serial_word_shifter bdm_sws_checker u_bdm_sws_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_clock_low_drive (o_clock_low_drive),
    .o_data_out        (o_data_out),
    .o_busy_res        (o_busy_res),
    .o_done_res        (o_done_res),
    .o_received_word   (o_received_word),
    .o_fault           (o_fault)
);

// ----- sim/tb.sv -----
// Testbench for the background debug serial word shifter: directed table, then random ticks.
module tb;
    import bdm_sws_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_OFF    = 120;
    localparam int unsigned QUIET_TICKS = 4;

    // One row of the directed table: pins held for reps transactions
    typedef struct {
        t_in_item    pins;
        int unsigned reps;
        bit          typed;
        t_out_item   want;
    } t_dir_row;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_cfg_we          = 1'b0;
    logic [15:0] i_cfg_data        = '0;
    logic        i_valid           = 1'b0;
    logic        o_ready;
    logic        i_start_req       = 1'b0;
    logic [15:0] i_send_word       = '0;
    logic        i_holdback        = 1'b0;
    logic        i_cable_connected = 1'b0;
    logic        i_target_powered  = 1'b0;
    logic        i_target_in_reset = 1'b0;
    logic        i_data_in_bar     = 1'b0;
    logic        o_valid;
    logic        i_ready           = 1'b0;
    logic        o_clock_low_drive;
    logic        o_data_out;
    logic        o_busy_res;
    logic        o_done_res;
    logic [16:0] o_received_word;
    logic [2:0]  o_fault;

    // Serial engine model state
    logic [15:0] eng_delay  = '0;
    logic [16:0] eng_shift  = '0;
    logic [4:0]  eng_bits   = '0;
    logic [15:0] eng_count  = '0;
    logic        eng_high   = 1'b0;
    logic        eng_active = 1'b0;
    logic        eng_dbit   = 1'b0;

    t_out_item   pin_out_q[$];
    int unsigned bad_ticks   = 0;
    int unsigned cycle_count = 0;
    bit          steady      = 1'b0;
    int unsigned hold_req    = 0;
    int unsigned hold_seen   = 0;
    int unsigned sink_hold   = 0;
    t_out_item   mon_want;
    t_out_item   mon_seen;

    localparam t_out_item IDLE_OUT = '{1'b0, 1'b0, 1'b0, 1'b0, 17'h0, FLT_OK};

    t_dir_row dir_rows[13] = '{
        '{'{1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 3, 1'b1, IDLE_OUT},
        '{'{1'b1, 16'h1234, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b1, 17'h0, FLT_CABLE}},
        '{'{1'b1, 16'h1234, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}, 1, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b1, 17'h0, FLT_POWER}},
        '{'{1'b1, 16'h1234, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}, 1, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b1, 17'h0, FLT_RESET}},
        // all ones shifted in, start kept high through the completing tick
        '{'{1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}, 34, 1'b0, IDLE_OUT},
        '{'{1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}, 2, 1'b1, IDLE_OUT},
        '{'{1'b1, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}, 34, 1'b0, IDLE_OUT},
        // held-back frame whose last sample makes the bus error word
        '{'{1'b1, 16'h0001, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}, 30, 1'b0, IDLE_OUT},
        '{'{1'b0, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}, 2, 1'b0, IDLE_OUT},
        // held-back frame that returns only the top bit
        '{'{1'b1, 16'h8001, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}, 32, 1'b0, IDLE_OUT},
        '{'{1'b1, 16'hAAAA, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}, 34, 1'b0, IDLE_OUT},
        '{'{1'b1, 16'h5555, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 32, 1'b0, IDLE_OUT},
        '{'{1'b0, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1}, 2, 1'b1, IDLE_OUT}
    };

    int unsigned delay_plan[9] = '{1, 2, 0, 3, 5, 12, 65535, 7, 0};
    int unsigned plan_items[9] = '{120, 120, 150, 120, 120, 120, 40, 120, 80};
    int unsigned din_biases[5] = '{0, 100, 50, 8, 92};

    bdm_serial_word_shifter i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_start_req       (i_start_req),
        .i_send_word       (i_send_word),
        .i_holdback        (i_holdback),
        .i_cable_connected (i_cable_connected),
        .i_target_powered  (i_target_powered),
        .i_target_in_reset (i_target_in_reset),
        .i_data_in_bar     (i_data_in_bar),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_clock_low_drive (o_clock_low_drive),
        .o_data_out        (o_data_out),
        .o_busy_res        (o_busy_res),
        .o_done_res        (o_done_res),
        .o_received_word   (o_received_word),
        .o_fault           (o_fault)
    );

    always #5 i_clk = ~i_clk;

    // Load the next frame bit and open its clock-low phase
    function automatic void next_bit();
        eng_dbit  = eng_shift[16];
        eng_shift = {eng_shift[15:0], 1'b0};
        eng_high  = 1'b0;
        eng_count = '0;
    endfunction

    // Advance the serial engine by one tick and return its pin outputs
    function automatic t_out_item engine_tick(input t_in_item pins);
        t_out_item r;
        r = '0;
        if (!eng_active) begin
            if (!pins.start_req)
                return r;
            if (!pins.cable_connected || !pins.target_powered || pins.target_in_reset) begin
                r.done_res = 1'b1;
                if (!pins.cable_connected)
                    r.fault = FLT_CABLE;
                else if (!pins.target_powered)
                    r.fault = FLT_POWER;
                else
                    r.fault = FLT_RESET;
                return r;
            end
            eng_active = 1'b1;
            eng_shift  = {1'b0, pins.send_word};
            eng_bits   = 5'(FRAME_BITS) - 5'(pins.holdback);
            next_bit();
        end
        r.data_out = eng_dbit;
        r.busy_res = 1'b1;
        if (!eng_high) begin
            r.clock_low_drive = 1'b1;
            // sample on the last clock-low tick
            if (eng_count == eng_delay) begin
                if (!pins.data_in_bar)
                    eng_shift[0] = 1'b1;
                eng_high  = 1'b1;
                eng_count = '0;
            end else begin
                eng_count = eng_count + 16'd1;
            end
            return r;
        end
        if (eng_count != (eng_delay >> 1)) begin
            eng_count = eng_count + 16'd1;
            return r;
        end
        eng_bits = eng_bits - 5'd1;
        if (eng_bits != 0) begin
            next_bit();
            return r;
        end
        // frame complete: report and classify the received word
        r.done_res      = 1'b1;
        r.received_word = eng_shift;
        if (eng_shift[16]) begin
            if (eng_shift == BERR_WORD)
                r.fault = FLT_BUS_ERR;
            else if (eng_shift != TOP_BIT)
                r.fault = FLT_NOT_VALID;
        end
        eng_active = 1'b0;
        eng_high   = 1'b0;
        eng_count  = '0;
        return r;
    endfunction

    // Offer one tick and hold it until accepted, then queue its outputs
    task automatic offer_tick(input t_in_item pins, input bit typed, input t_out_item want);
        t_out_item got;
        @(negedge i_clk);
        i_valid           <= 1'b1;
        i_start_req       <= pins.start_req;
        i_send_word       <= pins.send_word;
        i_holdback        <= pins.holdback;
        i_cable_connected <= pins.cable_connected;
        i_target_powered  <= pins.target_powered;
        i_target_in_reset <= pins.target_in_reset;
        i_data_in_bar     <= pins.data_in_bar;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        got = engine_tick(pins);
        pin_out_q.push_back(typed ? want : got);
    endtask

    // Idle the sender for a random number of cycles
    task automatic sender_gap();
        while (!steady && $urandom_range(99) < 27) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Drop valid and wait until every queued output has arrived
    task automatic quiet_wait();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pin_out_q.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_TICKS) @(posedge i_clk);
    endtask

    task automatic write_delay(input logic [15:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        eng_delay = d;
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            sink_hold = HOLD_OFF;
        end
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(99) >= 27);
        end
    end

    // Check each output transaction against the oldest queued one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            mon_seen = '{o_clock_low_drive, o_data_out, o_busy_res, o_done_res,
                         o_received_word, t_fault'(o_fault)};
            if (pin_out_q.size() == 0) begin
                if (bad_ticks < 10)
                    $display(
                        "extra output: clk=%0b dat=%0b busy=%0b done=%0b word=%05h flt=%0d",
                        mon_seen.clock_low_drive, mon_seen.data_out, mon_seen.busy_res,
                        mon_seen.done_res, mon_seen.received_word, mon_seen.fault);
                bad_ticks++;
            end else begin
                mon_want = pin_out_q.pop_front();
                if (mon_seen.clock_low_drive !== mon_want.clock_low_drive ||
                    mon_seen.data_out !== mon_want.data_out ||
                    mon_seen.busy_res !== mon_want.busy_res ||
                    mon_seen.done_res !== mon_want.done_res ||
                    mon_seen.received_word !== mon_want.received_word ||
                    mon_seen.fault !== mon_want.fault) begin
                    if (bad_ticks < 10) begin
                        $display(
                            "mismatch: want clk=%0b dat=%0b busy=%0b done=%0b word=%05h flt=%0d",
                            mon_want.clock_low_drive, mon_want.data_out, mon_want.busy_res,
                            mon_want.done_res, mon_want.received_word, mon_want.fault);
                        $display(
                            "          got  clk=%0b dat=%0b busy=%0b done=%0b word=%05h flt=%0d",
                            mon_seen.clock_low_drive, mon_seen.data_out, mon_seen.busy_res,
                            mon_seen.done_res, mon_seen.received_word, mon_seen.fault);
                    end
                    bad_ticks++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item    pins;
        int unsigned din_bias;
        bit          faults_only;
        din_bias    = 50;
        faults_only = 1'b0;
        pins        = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at the reset delay
        foreach (dir_rows[r]) begin
            repeat (dir_rows[r].reps) begin
                sender_gap();
                offer_tick(dir_rows[r].pins, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        foreach (delay_plan[p]) begin
            // finish any open frame, then reconfigure while idle
            while (eng_active) begin
                pins = '0;
                pins.data_in_bar = 1'($urandom_range(1));
                offer_tick(pins, 1'b0, IDLE_OUT);
            end
            quiet_wait();
            write_delay(16'(delay_plan[p]));
            faults_only = (delay_plan[p] == 65535);
            steady      = (p == 2);
            if (p == 1)
                hold_req++;

            for (int unsigned n = 0; n < plan_items[p]; n++) begin
                sender_gap();
                if (p == 3 && n == plan_items[p] / 2)
                    quiet_wait();
                pins.send_word       = 16'($urandom);
                pins.holdback        = 1'($urandom_range(1));
                pins.cable_connected = 1'($urandom_range(1));
                pins.target_powered  = 1'($urandom_range(1));
                pins.target_in_reset = 1'($urandom_range(1));
                if (!eng_active) begin
                    pins.start_req = ($urandom_range(99) < 45);
                    // mostly healthy pins so frames get going; only faulty pins when faults_only is set
                    if (faults_only) begin
                        if (pins.cable_connected && pins.target_powered &&
                            !pins.target_in_reset)
                            pins.target_in_reset = 1'b1;
                    end else if ($urandom_range(99) >= 15) begin
                        pins.cable_connected = 1'b1;
                        pins.target_powered  = 1'b1;
                        pins.target_in_reset = 1'b0;
                    end
                    if (pins.start_req)
                        din_bias = din_biases[$urandom_range(4)];
                end else begin
                    pins.start_req = 1'($urandom_range(1));
                end
                pins.data_in_bar = ($urandom_range(99) < din_bias);
                offer_tick(pins, 1'b0, IDLE_OUT);
            end
        end
        steady = 1'b0;

        // Drain and settle
        while (eng_active) begin
            pins = '0;
            offer_tick(pins, 1'b0, IDLE_OUT);
        end
        quiet_wait();
        repeat (8) @(posedge i_clk);

        if (bad_ticks == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- bdm_serial_word_shifter.f -----
rtl/bdm_sws_pkg.sv
rtl/bdm_sws_in_stage.sv
rtl/bdm_sws_core.sv
rtl/bdm_sws_out_stage.sv
rtl/bdm_serial_word_shifter.sv
rtl/bdm_sws_checker.sv
sim/tb.sv
